### rtl/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg
// Shared types, constants and the lead-byte classifier for the UTF-8
// stream validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ILL   = 2'd1;
    localparam logic [1:0] STATUS_TRUNC = 2'd2;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MIN   = 8'hC2;
    localparam logic [7:0] LEAD2_MAX   = 8'hDF;
    localparam logic [7:0] LEAD3_E0    = 8'hE0;
    localparam logic [7:0] LEAD3_ED    = 8'hED;
    localparam logic [7:0] LEAD3_MAX   = 8'hEF;
    localparam logic [7:0] LEAD4_F0    = 8'hF0;
    localparam logic [7:0] LEAD4_F4    = 8'hF4;
    localparam logic [7:0] TRAIL_LO    = 8'h80;
    localparam logic [7:0] TRAIL_HI    = 8'hBF;
    localparam logic [7:0] E0_CONT_MIN = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN = 8'h90;
    localparam logic [7:0] F4_CONT_MAX = 8'h8F;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       ascii;
        logic       lead_ok;
        logic [1:0] due;
        logic [7:0] nlo;
        logic [7:0] nhi;
    } byte_class_t;

    function automatic byte_class_t classify(input logic [7:0] b, input logic eom);
        byte_class_t c;
        c.data    = b;
        c.eom     = eom;
        c.ascii   = (b <= ASCII_MAX);
        c.lead_ok = 1'b1;
        c.due     = 2'd0;
        c.nlo     = TRAIL_LO;
        c.nhi     = TRAIL_HI;
        if (b >= LEAD2_MIN && b <= LEAD2_MAX)
        begin
            c.due = 2'd1;
        end
        else if (b >= LEAD3_E0 && b <= LEAD3_MAX)
        begin
            c.due = 2'd2;
            if (b == LEAD3_E0)
            begin
                c.nlo = E0_CONT_MIN;
            end
            else if (b == LEAD3_ED)
            begin
                c.nhi = ED_CONT_MAX;
            end
        end
        else if (b >= LEAD4_F0 && b <= LEAD4_F4)
        begin
            c.due = 2'd3;
            if (b == LEAD4_F0)
            begin
                c.nlo = F0_CONT_MIN;
            end
            else if (b == LEAD4_F4)
            begin
                c.nhi = F4_CONT_MAX;
            end
        end
        else
        begin
            c.lead_ok = 1'b0;
        end
        return c;
    endfunction

endpackage

### rtl/utf8_stream_validator.sv
// An accepted byte is written into the queue; when popped, its result is registered and result valid rises.
// Accepts one byte per cycle, sustained, while results are taken each cycle.
// The rate is set by the sequence-tracking registers, which update on every pop.
// Byte ready drops only when the QUEUE_DEPTH-entry queue is full.
// Reset (rst_n low, asynchronous) empties the queue, drops result valid, and
// clears the count of continuation bytes due, next-byte range and error flag.
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a byte stream for well-formed UTF-8, one byte per transfer, and
// returns a status and pending continuation count for every byte.
// ----------------------------------------------------------------------------
module utf8_stream_validator
    import u8sv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       byte_valid,
    output logic       byte_ready,
    output logic [1:0] status,
    output logic [1:0] pending_count,
    output logic       result_valid,
    input  logic       result_ready
);

    logic        push;
    byte_class_t push_data;
    logic        queue_full;
    logic        pop;
    logic        not_empty;
    byte_class_t pop_data;

    u8sv_front u_front (
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .queue_full     (queue_full),
        .push           (push),
        .push_data      (push_data)
    );

    u8sv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    u8sv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .not_empty     (not_empty),
        .pop_data      (pop_data),
        .pop           (pop),
        .status        (status),
        .pending_count (pending_count),
        .result_valid  (result_valid),
        .result_ready  (result_ready)
    );

`ifndef ASSERT_OFF
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == STATUS_OK || status == STATUS_ILL ||
                          status == STATUS_TRUNC))
        else $error("status carries an undefined code");

    a_ill_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STATUS_ILL |-> pending_count == 2'd0)
        else $error("ill-formed result reports pending continuation bytes");

    a_trunc_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == STATUS_TRUNC |-> pending_count != 2'd0)
        else $error("truncated result reports no missing bytes");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |=> byte_ready)
        else $error("input stalled although the result register was empty");
`endif

endmodule

### rtl/u8sv_front.sv
// ----------------------------------------------------------------------------
// u8sv_front
// Accepts bytes from the input channel and classifies each one against the
// lead-byte ranges before it enters the queue.
// ----------------------------------------------------------------------------
module u8sv_front
    import u8sv_pkg::*;
(
    input  logic        [7:0] data_byte,
    input  logic              end_of_message,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic              queue_full,
    output logic              push,
    output byte_class_t       push_data
);

    assign byte_ready = !queue_full;
    assign push       = byte_valid && !queue_full;
    assign push_data  = classify(data_byte, end_of_message);

endmodule

### rtl/u8sv_queue.sv
// ----------------------------------------------------------------------------
// u8sv_queue
// Short first-in first-out queue of classified bytes between the front and
// the back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module u8sv_queue
    import u8sv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output byte_class_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    byte_class_t     mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/u8sv_back.sv
// ----------------------------------------------------------------------------
// u8sv_back
// Sequence checker: tracks continuation bytes still due and their allowed
// range, holds the sticky error flag, and registers one result per byte.
// ----------------------------------------------------------------------------
module u8sv_back
    import u8sv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        not_empty,
    input  byte_class_t pop_data,
    output logic        pop,
    output logic [1:0]  status,
    output logic [1:0]  pending_count,
    output logic        result_valid,
    input  logic        result_ready
);

    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    logic [7:0] nlo_reg;
    logic [7:0] nlo_next;
    logic [7:0] nhi_reg;
    logic [7:0] nhi_next;
    logic       failed_reg;
    logic       failed_next;
    logic       valid_reg;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       ok;
    logic [1:0] rem_dec;

    assign pop           = not_empty && (!valid_reg || result_ready);
    assign result_valid  = valid_reg;
    assign status        = status_reg;
    assign pending_count = pend_reg;
    assign rem_dec       = rem_reg - 2'd1;

    always_comb
    begin
        rem_next    = rem_reg;
        nlo_next    = nlo_reg;
        nhi_next    = nhi_reg;
        failed_next = failed_reg;
        ok          = 1'b0;
        if (!failed_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                ok = pop_data.ascii || pop_data.lead_ok;
                if (pop_data.lead_ok)
                begin
                    rem_next = pop_data.due;
                    nlo_next = pop_data.nlo;
                    nhi_next = pop_data.nhi;
                end
            end
            else
            begin
                ok = (pop_data.data >= nlo_reg) && (pop_data.data <= nhi_reg);
                if (ok)
                begin
                    rem_next = rem_dec;
                    if (rem_dec != 2'd0)
                    begin
                        nlo_next = TRAIL_LO;
                        nhi_next = TRAIL_HI;
                    end
                end
            end
            if (!ok)
            begin
                failed_next = 1'b1;
                rem_next    = rem_reg;
                nlo_next    = nlo_reg;
                nhi_next    = nhi_reg;
            end
        end
        if (failed_next)
        begin
            status_next = STATUS_ILL;
            pend_next   = 2'd0;
        end
        else
        begin
            pend_next   = rem_next;
            status_next = (pop_data.eom && rem_next != 2'd0) ? STATUS_TRUNC : STATUS_OK;
        end
        if (pop_data.eom)
        begin
            rem_next    = 2'd0;
            nlo_next    = 8'h00;
            nhi_next    = 8'h00;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= 2'd0;
            nlo_reg    <= 8'h00;
            nhi_reg    <= 8'h00;
            failed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                rem_reg    <= rem_next;
                nlo_reg    <= nlo_next;
                nhi_reg    <= nhi_next;
                failed_reg <= failed_next;
                valid_reg  <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

### tb/sv/utf8_verdict_checker.sv
// ----------------------------------------------------------------------------
// utf8_verdict_checker
// Watches the byte and result channels of the UTF-8 stream validator. It
// tracks the decoder state for every accepted byte, queues the verdict that
// byte must produce, and compares each returned verdict with the oldest one.
// ----------------------------------------------------------------------------
module utf8_verdict_checker
    import u8sv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       byte_valid,
    input  logic       byte_ready,
    input  logic [1:0] status,
    input  logic [1:0] pending_count,
    input  logic       result_valid,
    input  logic       result_ready,
    output int         mismatches,
    output int         awaiting,
    output int         checked,
    output int         ill_seen,
    output int         trunc_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] pending;
    } byte_verdict_t;

    byte_verdict_t expected_verdicts[$];
    byte_verdict_t predicted;

    logic [1:0] cont_left;
    logic [7:0] cont_lo;
    logic [7:0] cont_hi;
    logic       seen_bad;

    task automatic open_sequence(input logic [1:0] due, input logic [7:0] lo,
                                 input logic [7:0] hi);
        cont_left = due;
        cont_lo   = lo;
        cont_hi   = hi;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output byte_verdict_t verdict);
        logic ok;
        ok = 1'b1;
        if (!seen_bad)
        begin
            if (cont_left == 2'd0)
            begin
                if (b <= 8'h7F)
                    ok = 1'b1;
                else if (b >= 8'hC2 && b <= 8'hDF)
                    open_sequence(2'd1, 8'h80, 8'hBF);
                else if (b == 8'hE0)
                    open_sequence(2'd2, 8'hA0, 8'hBF);
                else if (b >= 8'hE1 && b <= 8'hEC)
                    open_sequence(2'd2, 8'h80, 8'hBF);
                else if (b == 8'hED)
                    open_sequence(2'd2, 8'h80, 8'h9F);
                else if (b >= 8'hEE && b <= 8'hEF)
                    open_sequence(2'd2, 8'h80, 8'hBF);
                else if (b == 8'hF0)
                    open_sequence(2'd3, 8'h90, 8'hBF);
                else if (b >= 8'hF1 && b <= 8'hF3)
                    open_sequence(2'd3, 8'h80, 8'hBF);
                else if (b == 8'hF4)
                    open_sequence(2'd3, 8'h80, 8'h8F);
                else
                    ok = 1'b0;
            end
            else if (b < cont_lo || b > cont_hi)
            begin
                ok = 1'b0;
            end
            else
            begin
                cont_left = cont_left - 2'd1;
                if (cont_left != 2'd0)
                begin
                    cont_lo = 8'h80;
                    cont_hi = 8'hBF;
                end
            end
            if (!ok)
                seen_bad = 1'b1;
        end
        if (seen_bad)
        begin
            verdict.status  = STATUS_ILL;
            verdict.pending = 2'd0;
        end
        else
        begin
            verdict.pending = cont_left;
            verdict.status  = (last && cont_left != 2'd0) ? STATUS_TRUNC : STATUS_OK;
        end
        if (last)
        begin
            cont_left = 2'd0;
            cont_lo   = 8'h00;
            cont_hi   = 8'h00;
            seen_bad  = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_left = 2'd0;
            cont_lo   = 8'h00;
            cont_hi   = 8'h00;
            seen_bad  = 1'b0;
            expected_verdicts.delete();
            mismatches = 0;
            awaiting   = 0;
            checked    = 0;
            ill_seen   = 0;
            trunc_seen = 0;
        end
        else
        begin
            if (byte_valid && byte_ready)
            begin
                decode_byte(data_byte, end_of_message, predicted);
                expected_verdicts.push_back(predicted);
            end
            if (result_valid && result_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("Result transfer with status %0d and pending_count %0d had no byte outstanding.",
                           status, pending_count);
                    mismatches++;
                end
                else
                begin
                    predicted = expected_verdicts.pop_front();
                    checked++;
                    if (predicted.status == STATUS_ILL)
                        ill_seen++;
                    if (predicted.status == STATUS_TRUNC)
                        trunc_seen++;
                    if (status !== predicted.status)
                    begin
                        $error("status: expected %0d, actual %0d", predicted.status, status);
                        mismatches++;
                    end
                    if (pending_count !== predicted.pending)
                    begin
                        $error("pending_count: expected %0d, actual %0d",
                               predicted.pending, pending_count);
                        mismatches++;
                    end
                end
            end
            awaiting = expected_verdicts.size();
        end
    end

endmodule

### tb/sv/tb_utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_validator
// Drives directed and random byte messages into the UTF-8 stream validator:
// well-formed text across all lead ranges, ill-formed bytes and truncated
// sequences, under four flow phases. A separate checker predicts and compares
// every verdict; this module gives the final result.
// ----------------------------------------------------------------------------
module tb_utf8_stream_validator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1300;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_message = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    logic [1:0] status;
    logic [1:0] pending_count;
    logic       result_valid;
    logic       result_ready = 1'b0;

    int mismatches;
    int awaiting;
    int checked;
    int ill_seen;
    int trunc_seen;

    int gap_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int messages_sent = 0;
    int gap_tab[4] = '{0, 86, 0, 35};
    int stall_tab[4] = '{0, 0, 86, 35};

    stream_byte_t msg_q[$];
    stream_byte_t stim_q[$];

    utf8_stream_validator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_message(end_of_message),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .status        (status),
        .pending_count (pending_count),
        .result_valid  (result_valid),
        .result_ready  (result_ready)
    );

    utf8_verdict_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_message(end_of_message),
        .byte_valid    (byte_valid),
        .byte_ready    (byte_ready),
        .status        (status),
        .pending_count (pending_count),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .checked       (checked),
        .ill_seen      (ill_seen),
        .trunc_seen    (trunc_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_utf8_stream_validator: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] pick(input logic [7:0] lo, input logic [7:0] hi);
        int unsigned sel;
        sel = $urandom_range(3);
        if (sel == 0)
            return lo;
        if (sel == 1)
            return hi;
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic add_byte(input logic [7:0] v);
        stream_byte_t sb;
        sb.value = v;
        sb.last  = 1'b0;
        msg_q.push_back(sb);
    endtask

    task automatic close_message();
        msg_q[msg_q.size() - 1].last = 1'b1;
        foreach (msg_q[i])
            stim_q.push_back(msg_q[i]);
        msg_q.delete();
    endtask

    // A cut character keeps its lead byte and fewer continuations than it needs.
    task automatic add_char(input bit cut);
        logic [7:0] lo;
        logic [7:0] hi;
        int unsigned kind;
        int due;
        int keep;
        lo = 8'h80;
        hi = 8'hBF;
        kind = cut ? $urandom_range(9, 3) : $urandom_range(9);
        if (kind <= 2)
        begin
            add_byte(pick(8'h00, 8'h7F));
            return;
        end
        if (kind <= 4)
        begin
            due = 1;
            add_byte(pick(8'hC2, 8'hDF));
        end
        else if (kind <= 7)
        begin
            due = 2;
            case ($urandom_range(3))
                0:
                begin
                    add_byte(8'hE0);
                    lo = 8'hA0;
                end
                1: add_byte(pick(8'hE1, 8'hEC));
                2:
                begin
                    add_byte(8'hED);
                    hi = 8'h9F;
                end
                default: add_byte(pick(8'hEE, 8'hEF));
            endcase
        end
        else
        begin
            due = 3;
            case ($urandom_range(2))
                0:
                begin
                    add_byte(8'hF0);
                    lo = 8'h90;
                end
                1: add_byte(pick(8'hF1, 8'hF3));
                default:
                begin
                    add_byte(8'hF4);
                    hi = 8'h8F;
                end
            endcase
        end
        keep = cut ? $urandom_range(due - 1) : due;
        for (int k = 0; k < keep; k++)
        begin
            add_byte(pick(lo, hi));
            lo = 8'h80;
            hi = 8'hBF;
        end
    endtask

    task automatic add_bad();
        case ($urandom_range(7))
            0: add_byte(pick(8'hC0, 8'hC1));
            1: add_byte(pick(8'hF5, 8'hFF));
            2: add_byte(pick(8'h80, 8'hBF));
            3:
            begin
                add_byte(8'hE0);
                add_byte(pick(8'h80, 8'h9F));
            end
            4:
            begin
                add_byte(8'hED);
                add_byte(pick(8'hA0, 8'hBF));
            end
            5:
            begin
                add_byte(8'hF0);
                add_byte(pick(8'h80, 8'h8F));
            end
            6:
            begin
                add_byte(8'hF4);
                add_byte(pick(8'h90, 8'hBF));
            end
            default:
            begin
                add_byte(pick(8'hC2, 8'hDF));
                add_byte($urandom_range(1) ? pick(8'h00, 8'h7F) : pick(8'hC0, 8'hFF));
            end
        endcase
    endtask

    task automatic add_message();
        int unsigned shape;
        shape = $urandom_range(99);
        repeat ($urandom_range(8))
            add_char(1'b0);
        if (shape < 68)
        begin
            add_char(1'b0);
        end
        else if (shape < 82)
        begin
            add_bad();
            repeat ($urandom_range(2))
                add_byte(8'($urandom));
        end
        else if (shape < 92)
        begin
            add_char(1'b1);
        end
        else
        begin
            msg_q.delete();
            repeat ($urandom_range(6, 1))
                add_byte(8'($urandom));
        end
        close_message();
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_byte(input stream_byte_t sb);
        if ($urandom_range(99) < gap_pct)
        begin
            byte_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        data_byte      <= sb.value;
        end_of_message <= sb.last;
        byte_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!byte_ready);
        @(negedge clk);
    endtask

    initial
    begin
        int n_directed;
        int phase;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_byte(8'h00);
        close_message();
        add_byte(8'h7F);
        add_byte(8'hC2); add_byte(8'h80);
        add_byte(8'hDF); add_byte(8'hBF);
        add_byte(8'hE0); add_byte(8'hA0); add_byte(8'h80);
        add_byte(8'hED); add_byte(8'h9F); add_byte(8'hBF);
        add_byte(8'hF0); add_byte(8'h90); add_byte(8'h80); add_byte(8'h80);
        add_byte(8'hF4); add_byte(8'h8F); add_byte(8'hBF); add_byte(8'hBF);
        close_message();
        add_byte(8'hE1);
        close_message();
        add_byte(8'hFF); add_byte(8'h41);
        close_message();
        add_byte(8'hF0); add_byte(8'h8F);
        close_message();
        n_directed = stim_q.size();

        while (stim_q.size() < n_directed + RANDOM_BYTES)
            add_message();

        foreach (stim_q[i])
        begin
            if (i >= n_directed)
            begin
                phase = ((i - n_directed) * 4) / (stim_q.size() - n_directed);
                gap_pct = gap_tab[phase];
                stall_pct = stall_tab[phase];
            end
            send_byte(stim_q[i]);
            if (stim_q[i].last)
                messages_sent++;
        end
        byte_valid <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;

        while (awaiting != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d bytes in %0d messages; %0d verdicts checked, %0d ill-formed, %0d truncated.",
                 stim_q.size(), messages_sent, checked, ill_seen, trunc_seen);
        $display("Flow phases covered: free-running, sparse sender, stalled receiver, both idling.");
        if (mismatches == 0)
            $display("tb_utf8_stream_validator: PASS");
        else
            $display("tb_utf8_stream_validator: FAIL");
        $finish;
    end

endmodule
